// File: sv/gbt4_pkg.sv
// Shared types and constants for the tiled 4bpp glyph blitter.
package gbt4_pkg;

   // Default size of the window tile store in bytes.
   localparam int WINDOW_BYTES_DEF = 8192;

   // Width of a computed window byte address before the range check.
   localparam int CALC_W = 17;

   // Reset values of the configuration registers.
   localparam logic [5:0] WIDTH_TILES_RST  = 6'd32;
   localparam logic [5:0] HEIGHT_TILES_RST = 6'd8;

   // Largest glyph edge in pixels.
   localparam logic [4:0] GLYPH_MAX = 5'd16;

   // Request actions.
   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_DRAW  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_WRITE = 2'd3
   } action_type;

   // Configuration register indexes.
   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_ROW,
      ST_BYTES,
      ST_DRAIN,
      ST_RDWAIT,
      ST_DONE
   } state_type;

endpackage

// File: sv/glyph_blit_tiled_4bpp_top.sv
// Tiled 4bpp transparent glyph blitter with its window and glyph stores.
//
// Requests arrive on the req_ channel and each transaction gives exactly one
// response on the rsp_ channel, in order. Action 0 loads one 32-bit glyph row
// word, action 1 draws the loaded glyph at the cursor with clipping, action 2
// reads one window byte and action 3 writes one window byte.
// The block works on one transaction at a time. A draw sets up the clip, then
// for each visible row computes the row start and walks its bytes, then drains.
// One window byte is read in each cycle of a row through the window memory's
// read port and written back in the next cycle, so within a row a draw moves
// at one byte per cycle.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next transaction finishes its work and
// then waits until the response register is free.
// After reset the window memory is cleared one byte a cycle; req_ready stays
// low until then. Configuration writes on the csr_ port are taken at any time.
// Glyph words are undefined until loaded.
module glyph_blit_tiled_4bpp_top #(
   parameter int WINDOW_BYTES = gbt4_pkg::WINDOW_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_glyph_word,
   input  logic [7:0]  req_cursor_x,
   input  logic [7:0]  req_cursor_y,
   input  logic [4:0]  req_glyph_width,
   input  logic [4:0]  req_glyph_height,
   input  logic [12:0] req_byte_address,
   input  logic [7:0]  req_byte_data,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [8:0]  rsp_pixels_written,
   output logic        rsp_status,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam int CW = gbt4_pkg::CALC_W;
   localparam logic [CW-1:0] LIMIT = CW'(WINDOW_BYTES);
   localparam logic [AW-1:0] CLR_LAST = AW'(WINDOW_BYTES - 1);

   // Storage.
   logic [7:0]  win_mem [WINDOW_BYTES];
   logic [31:0] glyph_lo_mem [16];
   logic [31:0] glyph_hi_mem [16];

   // Control state.
   gbt4_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [5:0]    wt_ff, ht_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          s1_we_ff, s1_we_in;

   // Transaction payload registers.
   logic [7:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [4:0]    gw_ff, gw_in, gh_ff, gh_in;
   logic [4:0]    vw_ff, vw_in, vh_ff, vh_in;
   logic [7:0]    bx_ff, bx_in, bx_last_ff, bx_last_in;
   logic [3:0]    y_ff, y_in;
   logic [CW-1:0] row_base_ff, row_base_in;
   logic [8:0]    count_ff, count_in;
   logic          flag_ff, flag_in;
   logic [7:0]    rdata_ff, rdata_in;
   logic [AW-1:0] s1_addr_ff, s1_addr_in;
   logic [3:0]    s1_pe_ff, s1_pe_in, s1_po_ff, s1_po_in;
   logic          s1_me_ff, s1_me_in, s1_mo_ff, s1_mo_in;
   logic [7:0]    rsp_rdata_ff;
   logic [8:0]    rsp_count_ff;
   logic          rsp_flag_ff;

   // Memory read data registers.
   logic [7:0]    win_rdata_ff;
   logic [31:0]   glyph_lo_rd_ff, glyph_hi_rd_ff;

   // Combinational signals.
   gbt4_pkg::action_type act_c;
   logic          req_fire;
   logic          csr_wr;
   logic [CW-1:0] req_addr_ext;
   logic          req_addr_ok;
   logic          win_we;
   logic [AW-1:0] win_waddr, win_raddr;
   logic [7:0]    win_wdata;
   logic          rsp_load;
   logic signed [9:0] room_w, room_h;
   logic [4:0]    want_w, want_h, vw_c, vh_c;
   logic [8:0]    x_end;
   logic [8:0]    ypos;
   logic [11:0]   row_prod;
   logic [CW-1:0] issue_addr;
   logic          issue_ok;
   logic signed [9:0] ux_e, ux_o;
   logic          val_e, val_o, ok_e, ok_o;
   logic [63:0]   glyph_row;
   logic [3:0]    pix_e, pix_o;
   logic          last_byte, last_row;

   assign act_c        = gbt4_pkg::action_type'(req_action);
   assign req_fire     = req_valid && req_ready;
   assign req_addr_ext = CW'(req_byte_address);
   assign req_addr_ok  = req_addr_ext < LIMIT;

   // Configuration registers: written on the access phase, read back by index.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      unique case (gbt4_pkg::reg_index_type'(csr_paddr[2]))
         gbt4_pkg::REG_WIDTH:  csr_prdata = {26'd0, wt_ff};
         gbt4_pkg::REG_HEIGHT: csr_prdata = {26'd0, ht_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_ff <= gbt4_pkg::WIDTH_TILES_RST;
         ht_ff <= gbt4_pkg::HEIGHT_TILES_RST;
      end else if (csr_wr) begin
         unique case (gbt4_pkg::reg_index_type'(csr_paddr[2]))
            gbt4_pkg::REG_WIDTH:  wt_ff <= csr_pwdata[5:0];
            gbt4_pkg::REG_HEIGHT: ht_ff <= csr_pwdata[5:0];
         endcase
      end
   end

   // Clipping of the glyph against the window, from the latched request.
   assign room_w = $signed({1'b0, wt_ff, 3'b000}) - $signed({2'b00, cx_ff});
   assign room_h = $signed({1'b0, ht_ff, 3'b000}) - $signed({2'b00, cy_ff});
   assign want_w = (gw_ff > gbt4_pkg::GLYPH_MAX) ? gbt4_pkg::GLYPH_MAX : gw_ff;
   assign want_h = (gh_ff > gbt4_pkg::GLYPH_MAX) ? gbt4_pkg::GLYPH_MAX : gh_ff;

   always_comb begin
      if (room_w <= 10'sd0) begin
         vw_c = 5'd0;
      end else if (room_w < $signed({5'd0, want_w})) begin
         vw_c = room_w[4:0];
      end else begin
         vw_c = want_w;
      end
      if (room_h <= 10'sd0) begin
         vh_c = 5'd0;
      end else if (room_h < $signed({5'd0, want_h})) begin
         vh_c = room_h[4:0];
      end else begin
         vh_c = want_h;
      end
   end

   // Last pixel column of the visible glyph, used to find the last byte column.
   assign x_end = {1'b0, cx_ff} + {4'd0, vw_c} - 9'd1;

   // Start of the current window row: tile row times stride plus row in tile.
   assign ypos     = {1'b0, cy_ff} + {5'd0, y_ff};
   assign row_prod = ypos[8:3] * wt_ff;

   // Byte issue: address of the current byte column and its two pixels.
   assign issue_addr = row_base_ff + CW'({bx_ff[7:2], 5'd0}) + CW'(bx_ff[1:0]);
   assign issue_ok   = issue_addr < LIMIT;
   assign ux_e       = $signed({1'b0, bx_ff, 1'b0}) - $signed({2'b00, cx_ff});
   assign ux_o       = ux_e + 10'sd1;
   assign val_e      = !ux_e[9] && (ux_e < $signed({5'd0, vw_ff}));
   assign val_o      = !ux_o[9] && (ux_o < $signed({5'd0, vw_ff}));
   assign glyph_row  = {glyph_hi_rd_ff, glyph_lo_rd_ff};
   assign pix_e      = glyph_row[{ux_e[3:0], 2'b00} +: 4];
   assign pix_o      = glyph_row[{ux_o[3:0], 2'b00} +: 4];
   assign ok_e       = val_e && (pix_e != 4'd0);
   assign ok_o       = val_o && (pix_o != 4'd0);
   assign last_byte  = (bx_ff == bx_last_ff);
   assign last_row   = ({1'b0, y_ff} == (vh_ff - 5'd1));

   assign rsp_load = (state_ff == gbt4_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbt4_pkg::ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = gbt4_pkg::ST_IDLE;
         end
         gbt4_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (act_c)
                  gbt4_pkg::ACT_LOAD:  state_in = gbt4_pkg::ST_DONE;
                  gbt4_pkg::ACT_WRITE: state_in = gbt4_pkg::ST_DONE;
                  gbt4_pkg::ACT_READ:  state_in = gbt4_pkg::ST_RDWAIT;
                  gbt4_pkg::ACT_DRAW:  state_in = gbt4_pkg::ST_SETUP;
               endcase
            end
         end
         gbt4_pkg::ST_SETUP: begin
            if (vw_c == 5'd0 || vh_c == 5'd0) begin
               state_in = gbt4_pkg::ST_DONE;
            end else begin
               state_in = gbt4_pkg::ST_ROW;
            end
         end
         gbt4_pkg::ST_ROW:    state_in = gbt4_pkg::ST_BYTES;
         gbt4_pkg::ST_BYTES: begin
            if (last_byte) state_in = last_row ? gbt4_pkg::ST_DRAIN : gbt4_pkg::ST_ROW;
         end
         gbt4_pkg::ST_DRAIN:  state_in = gbt4_pkg::ST_DONE;
         gbt4_pkg::ST_RDWAIT: state_in = gbt4_pkg::ST_DONE;
         gbt4_pkg::ST_DONE: begin
            if (rsp_load) state_in = gbt4_pkg::ST_IDLE;
         end
      endcase
   end

   // State-driven outputs: handshake and window memory port selection.
   always_comb begin
      req_ready = (state_ff == gbt4_pkg::ST_IDLE);
      win_raddr = (state_ff == gbt4_pkg::ST_IDLE) ? req_addr_ext[AW-1:0]
                                                  : issue_addr[AW-1:0];
      win_we    = 1'b0;
      win_waddr = s1_addr_ff;
      win_wdata = {s1_mo_ff ? s1_po_ff : win_rdata_ff[7:4],
                   s1_me_ff ? s1_pe_ff : win_rdata_ff[3:0]};
      priority if (state_ff == gbt4_pkg::ST_CLEAR) begin
         win_we    = 1'b1;
         win_waddr = clr_ff;
         win_wdata = 8'd0;
      end else if (req_fire && act_c == gbt4_pkg::ACT_WRITE) begin
         win_we    = req_addr_ok;
         win_waddr = req_addr_ext[AW-1:0];
         win_wdata = req_byte_data;
      end else if (s1_we_ff) begin
         win_we = 1'b1;
      end
   end

   // Datapath next values.
   always_comb begin
      clr_in      = clr_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      gw_in       = gw_ff;
      gh_in       = gh_ff;
      vw_in       = vw_ff;
      vh_in       = vh_ff;
      bx_in       = bx_ff;
      bx_last_in  = bx_last_ff;
      y_in        = y_ff;
      row_base_in = row_base_ff;
      count_in    = count_ff;
      flag_in     = flag_ff;
      rdata_in    = rdata_ff;
      s1_we_in    = 1'b0;
      s1_addr_in  = issue_addr[AW-1:0];
      s1_pe_in    = pix_e;
      s1_po_in    = pix_o;
      s1_me_in    = ok_e;
      s1_mo_in    = ok_o;
      unique case (state_ff)
         gbt4_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         gbt4_pkg::ST_IDLE: begin
            if (req_fire) begin
               cx_in    = req_cursor_x;
               cy_in    = req_cursor_y;
               gw_in    = req_glyph_width;
               gh_in    = req_glyph_height;
               count_in = 9'd0;
               rdata_in = 8'd0;
               flag_in  = (act_c == gbt4_pkg::ACT_READ || act_c == gbt4_pkg::ACT_WRITE)
                          && !req_addr_ok;
            end
         end
         gbt4_pkg::ST_SETUP: begin
            vw_in      = vw_c;
            vh_in      = vh_c;
            bx_in      = {1'b0, cx_ff[7:1]};
            bx_last_in = x_end[8:1];
            y_in       = 4'd0;
         end
         gbt4_pkg::ST_ROW: begin
            row_base_in = CW'({row_prod, 5'd0}) + CW'({ypos[2:0], 2'b00});
         end
         gbt4_pkg::ST_BYTES: begin
            if (issue_ok) begin
               count_in = count_ff + 9'(ok_e) + 9'(ok_o);
               s1_we_in = ok_e || ok_o;
            end else if (ok_e || ok_o) begin
               flag_in = 1'b1;
            end
            bx_in = bx_ff + 8'd1;
            if (last_byte) begin
               bx_in = {1'b0, cx_ff[7:1]};
               y_in  = y_ff + 4'd1;
            end
         end
         gbt4_pkg::ST_DRAIN: begin
         end
         gbt4_pkg::ST_RDWAIT: begin
            rdata_in = flag_ff ? 8'd0 : win_rdata_ff;
         end
         gbt4_pkg::ST_DONE: begin
         end
      endcase
   end

   // Response register: loaded once the slot is free, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbt4_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         s1_we_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_we_ff     <= s1_we_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      gw_ff       <= gw_in;
      gh_ff       <= gh_in;
      vw_ff       <= vw_in;
      vh_ff       <= vh_in;
      bx_ff       <= bx_in;
      bx_last_ff  <= bx_last_in;
      y_ff        <= y_in;
      row_base_ff <= row_base_in;
      count_ff    <= count_in;
      flag_ff     <= flag_in;
      rdata_ff    <= rdata_in;
      s1_addr_ff  <= s1_addr_in;
      s1_pe_ff    <= s1_pe_in;
      s1_po_ff    <= s1_po_in;
      s1_me_ff    <= s1_me_in;
      s1_mo_ff    <= s1_mo_in;
      if (rsp_load) begin
         rsp_rdata_ff <= rdata_ff;
         rsp_count_ff <= count_ff;
         rsp_flag_ff  <= flag_ff;
      end
   end

   // Window memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= win_wdata;
      end
      win_rdata_ff <= win_mem[win_raddr];
   end

   // Glyph memories: left tiles and right tiles, read together as one row.
   always_ff @(posedge clock) begin
      if (req_fire && act_c == gbt4_pkg::ACT_LOAD) begin
         if (req_word_index[3]) begin
            glyph_hi_mem[{req_word_index[4], req_word_index[2:0]}] <= req_glyph_word;
         end else begin
            glyph_lo_mem[{req_word_index[4], req_word_index[2:0]}] <= req_glyph_word;
         end
      end
      glyph_lo_rd_ff <= glyph_lo_mem[y_ff];
      glyph_hi_rd_ff <= glyph_hi_mem[y_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_rdata_ff;
   assign rsp_pixels_written = rsp_count_ff;
   assign rsp_status         = rsp_flag_ff;

endmodule

// File: dv/glyph_blit_checker.sv
`timescale 1ns / 1ps
// Response checker for the tiled 4bpp glyph blitter: predicts and compares every transaction.
module glyph_blit_checker #(
   parameter int WINDOW_BYTES = gbt4_pkg::WINDOW_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_glyph_word,
   input  logic [7:0]  req_cursor_x,
   input  logic [7:0]  req_cursor_y,
   input  logic [4:0]  req_glyph_width,
   input  logic [4:0]  req_glyph_height,
   input  logic [12:0] req_byte_address,
   input  logic [7:0]  req_byte_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_read_data,
   input  logic [8:0]  rsp_pixels_written,
   input  logic        rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          outstanding
);

   typedef struct {
      gbt4_pkg::action_type act;
      logic [7:0] read_data;
      logic [8:0] pixels_written;
      logic       status;
   } blit_response_type;

   // Our own copy of the block's stores and window registers.
   logic [7:0]  window_mem [WINDOW_BYTES];
   logic [31:0] glyph_rows [32];
   logic [5:0]  width_tiles = gbt4_pkg::WIDTH_TILES_RST;
   logic [5:0]  height_tiles = gbt4_pkg::HEIGHT_TILES_RST;

   blit_response_type expected_responses[$];
   int errors = 0;

   initial begin
      foreach (window_mem[i]) window_mem[i] = 8'h00;
      foreach (glyph_rows[i]) glyph_rows[i] = 32'h0;
   end

   // Count a failure; only the first few are described.
   task automatic note_failure(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endtask

   // Visible extent along one axis; zero or negative means nothing is drawn.
   function automatic int clip_span(int tiles, int cursor, int size);
      int room;
      int want;
      room = tiles * 8 - cursor;
      want = (size > 16) ? 16 : size;
      return (room < want) ? room : want;
   endfunction

   // Apply one transaction to the shadow stores and work out its response.
   function automatic blit_response_type predict_response(
      gbt4_pkg::action_type act, logic [4:0] widx, logic [31:0] gword,
      logic [7:0] cx, logic [7:0] cy, logic [4:0] gw, logic [4:0] gh,
      logic [12:0] baddr, logic [7:0] bdata);
      blit_response_type r;
      int vis_w;
      int vis_h;
      int xpos;
      int ypos;
      int addr;
      logic [3:0] pix;
      logic [4:0] row_sel;
      r.act = act;
      r.read_data = 8'h00;
      r.pixels_written = 9'd0;
      r.status = 1'b0;
      case (act)
         gbt4_pkg::ACT_LOAD: begin
            glyph_rows[widx] = gword;
         end
         gbt4_pkg::ACT_DRAW: begin
            vis_w = clip_span(int'(width_tiles), int'(cx), int'(gw));
            vis_h = clip_span(int'(height_tiles), int'(cy), int'(gh));
            for (int y = 0; y < vis_h; y++) begin
               for (int x = 0; x < vis_w; x++) begin
                  // Glyph tile quadrant from the high bits, row within tile from the low bits.
                  row_sel = {y[3], x[3], y[2:0]};
                  pix = glyph_rows[row_sel][x[2:0] * 4 +: 4];
                  if (pix == 4'h0) continue;
                  xpos = int'(cx) + x;
                  ypos = int'(cy) + y;
                  addr = ((xpos >> 1) & 3) + ((xpos >> 3) << 5)
                       + (((ypos >> 3) * int'(width_tiles)) << 5) + ((ypos & 7) << 2);
                  if (addr >= WINDOW_BYTES) begin
                     r.status = 1'b1;
                     continue;
                  end
                  // Odd columns live in the high nibble.
                  if (xpos[0]) window_mem[addr][7:4] = pix;
                  else window_mem[addr][3:0] = pix;
                  r.pixels_written = r.pixels_written + 9'd1;
               end
            end
         end
         gbt4_pkg::ACT_READ: begin
            if (int'(baddr) < WINDOW_BYTES) r.read_data = window_mem[baddr];
            else r.status = 1'b1;
         end
         default: begin
            if (int'(baddr) < WINDOW_BYTES) window_mem[baddr] = bdata;
            else r.status = 1'b1;
         end
      endcase
      return r;
   endfunction

   // Compare responses first, then queue the prediction for a new request.
   always @(posedge clock) begin : watch
      blit_response_type exp_r;
      logic [5:0] reg_value;
      if (reset) begin
         width_tiles = gbt4_pkg::WIDTH_TILES_RST;
         height_tiles = gbt4_pkg::HEIGHT_TILES_RST;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               note_failure($sformatf("unexpected response: read_data %0h pixels_written %0d status %0d",
                                      rsp_read_data, rsp_pixels_written, rsp_status));
            end else begin
               exp_r = expected_responses.pop_front();
               if (rsp_read_data !== exp_r.read_data ||
                   rsp_pixels_written !== exp_r.pixels_written ||
                   rsp_status !== exp_r.status) begin
                  note_failure($sformatf(
                     "%s mismatch: read_data exp %0h got %0h, pixels_written exp %0d got %0d, status exp %0d got %0d",
                     exp_r.act.name(), exp_r.read_data, rsp_read_data,
                     exp_r.pixels_written, rsp_pixels_written, exp_r.status, rsp_status));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_responses.push_back(predict_response(gbt4_pkg::action_type'(req_action),
               req_word_index, req_glyph_word, req_cursor_x, req_cursor_y,
               req_glyph_width, req_glyph_height, req_byte_address, req_byte_data));
         end
         // Register writes update our copy; reads are checked against it.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (gbt4_pkg::reg_index_type'(csr_paddr[2]))
                  gbt4_pkg::REG_WIDTH:  width_tiles = csr_pwdata[5:0];
                  gbt4_pkg::REG_HEIGHT: height_tiles = csr_pwdata[5:0];
               endcase
            end else begin
               reg_value = (gbt4_pkg::reg_index_type'(csr_paddr[2]) == gbt4_pkg::REG_HEIGHT)
                           ? height_tiles : width_tiles;
               if (csr_prdata !== {26'd0, reg_value}) begin
                  note_failure($sformatf("register readback at %0h: exp %0h got %0h",
                                         csr_paddr, reg_value, csr_prdata));
               end
            end
         end
      end
      outstanding <= expected_responses.size();
      mismatches <= errors;
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the tiled 4bpp glyph blitter: clock, reset, stimulus and verdict.
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = gbt4_pkg::ACT_LOAD;
   logic [4:0]  req_word_index = 5'd0;
   logic [31:0] req_glyph_word = 32'd0;
   logic [7:0]  req_cursor_x = 8'd0;
   logic [7:0]  req_cursor_y = 8'd0;
   logic [4:0]  req_glyph_width = 5'd0;
   logic [4:0]  req_glyph_height = 5'd0;
   logic [12:0] req_byte_address = 13'd0;
   logic [7:0]  req_byte_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [8:0]  rsp_pixels_written;
   logic        rsp_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int   mismatches;
   int   outstanding;
   logic steady = 1'b0;
   int   cur_w = 32;
   int   cur_h = 8;

   glyph_blit_tiled_4bpp_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_word_index(req_word_index), .req_glyph_word(req_glyph_word),
      .req_cursor_x(req_cursor_x), .req_cursor_y(req_cursor_y),
      .req_glyph_width(req_glyph_width), .req_glyph_height(req_glyph_height),
      .req_byte_address(req_byte_address), .req_byte_data(req_byte_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_data(rsp_read_data),
      .rsp_pixels_written(rsp_pixels_written), .rsp_status(rsp_status),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   glyph_blit_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_word_index(req_word_index), .req_glyph_word(req_glyph_word),
      .req_cursor_x(req_cursor_x), .req_cursor_y(req_cursor_y),
      .req_glyph_width(req_glyph_width), .req_glyph_height(req_glyph_height),
      .req_byte_address(req_byte_address), .req_byte_data(req_byte_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_data(rsp_read_data),
      .rsp_pixels_written(rsp_pixels_written), .rsp_status(rsp_status),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 37);
   end

   // Hard limit on the run time.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // One request transaction; valid stays up across back-to-back transactions.
   task automatic send_request(gbt4_pkg::action_type act, logic [4:0] widx,
                               logic [31:0] gword,
                               logic [7:0] cx, logic [7:0] cy, logic [4:0] gw,
                               logic [4:0] gh, logic [12:0] baddr, logic [7:0] bdata);
      while (!steady && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_word_index <= widx;
      req_glyph_word <= gword;
      req_cursor_x <= cx;
      req_cursor_y <= cy;
      req_glyph_width <= gw;
      req_glyph_height <= gh;
      req_byte_address <= baddr;
      req_byte_data <= bdata;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Per-action wrappers; fields the action ignores get random values.
   task automatic do_load(logic [4:0] widx, logic [31:0] gword);
      send_request(gbt4_pkg::ACT_LOAD, widx, gword, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                   5'($urandom_range(0, 31)), 13'($urandom_range(0, 8191)),
                   8'($urandom_range(0, 255)));
   endtask

   task automatic do_draw(logic [7:0] cx, logic [7:0] cy, logic [4:0] gw, logic [4:0] gh);
      send_request(gbt4_pkg::ACT_DRAW, 5'($urandom_range(0, 31)), $urandom(), cx, cy,
                   gw, gh, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
   endtask

   task automatic do_read(logic [12:0] baddr);
      send_request(gbt4_pkg::ACT_READ, 5'($urandom_range(0, 31)), $urandom(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                   baddr, 8'($urandom_range(0, 255)));
   endtask

   task automatic do_write(logic [12:0] baddr, logic [7:0] bdata);
      send_request(gbt4_pkg::ACT_WRITE, 5'($urandom_range(0, 31)), $urandom(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                   baddr, bdata);
   endtask

   // One register access: setup cycle, access cycle, then a cycle with the bus idle.
   task automatic csr_access(gbt4_pkg::reg_index_type idx, logic write, logic [5:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {26'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every response has come back, then a margin.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_window(int w, int h);
      csr_access(gbt4_pkg::REG_WIDTH, 1'b1, w[5:0]);
      csr_access(gbt4_pkg::REG_HEIGHT, 1'b1, h[5:0]);
      csr_access(gbt4_pkg::REG_WIDTH, 1'b0, 6'd0);
      csr_access(gbt4_pkg::REG_HEIGHT, 1'b0, 6'd0);
      cur_w = w;
      cur_h = h;
   endtask

   // A glyph row with no transparent pixel.
   function automatic logic [31:0] dense_word();
      logic [31:0] w;
      for (int n = 0; n < 8; n++) w[4 * n +: 4] = 4'($urandom_range(1, 15));
      return w;
   endfunction

   // Cursor mostly inside the window, sometimes near its far edge, sometimes anywhere.
   function automatic logic [7:0] pick_cursor(int tiles);
      int span;
      int r;
      int near;
      span = tiles * 8;
      r = $urandom_range(0, 99);
      if (span == 0 || r < 15) return 8'($urandom_range(0, 255));
      if (r < 35) begin
         near = span - int'($urandom_range(1, 16));
         if (near < 0) near = 0;
         if (near > 255) near = 255;
         return 8'(near);
      end
      return 8'($urandom_range(0, ((span > 256) ? 256 : span) - 1));
   endfunction

   function automatic logic [4:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 5'd0;
      if (r < 18) return 5'($urandom_range(17, 31));
      return 5'($urandom_range(1, 16));
   endfunction

   // Random transaction mix shaped by the current window size.
   task automatic send_random_request();
      int pick;
      int area;
      logic [31:0] word;
      logic [12:0] addr;
      pick = $urandom_range(0, 99);
      area = cur_w * cur_h * 32;
      if (area == 0 || area > 8192) area = 8192;
      if ($urandom_range(0, 1)) addr = 13'($urandom_range(0, area - 1));
      else addr = 13'($urandom_range(0, 8191));
      if (pick < 20) begin
         case ($urandom_range(0, 2))
            0: word = $urandom();
            1: word = dense_word();
            default: word = $urandom() & $urandom();
         endcase
         do_load(5'($urandom_range(0, 31)), word);
      end else if (pick < 50) begin
         do_draw(pick_cursor(cur_w), pick_cursor(cur_h), pick_size(), pick_size());
      end else if (pick < 75) begin
         do_read(addr);
      end else begin
         do_write(addr, 8'($urandom_range(0, 255)));
      end
   endtask

   // Window size and transaction count of each random phase.
   task automatic phase_plan(int p, output int w, output int h, output int n);
      case (p)
         0: begin w = 32; h = 8;  n = 150; end
         1: begin w = 1;  h = 1;  n = 60;  end
         2: begin w = 32; h = 32; n = 150; end
         3: begin w = 16; h = 4;  n = 120; end
         4: begin w = 1;  h = 32; n = 60;  end
         5: begin w = 0;  h = 63; n = 30;  end
         6: begin w = 63; h = 0;  n = 30;  end
         7: begin w = 63; h = 63; n = 100; end
         default: begin w = 7; h = 5; n = 100; end
      endcase
   endtask

   initial begin : stimulus
      int w;
      int h;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Every glyph word is loaded before the first draw.
      for (int i = 0; i < 32; i++) do_load(5'(i), dense_word());

      // Directed transactions with the reset window of 32 by 8 tiles.
      do_draw(8'd0, 8'd0, 5'd16, 5'd16);
      do_read(13'd0);
      do_read(13'h1FFF);
      do_write(13'h1FFF, 8'hFF);
      do_read(13'h1FFF);
      do_write(13'd0, 8'h00);
      do_read(13'd1);
      do_load(5'd0, 32'h0000_0000);
      do_load(5'd5, 32'hF0F0_F0F0);
      do_load(5'd31, 32'hFFFF_FFFF);
      do_load(5'd18, 32'h0000_000F);
      do_draw(8'd3, 8'd5, 5'd16, 5'd16);
      do_draw(8'd250, 8'd60, 5'd16, 5'd16);
      do_draw(8'd255, 8'd255, 5'd16, 5'd16);
      do_draw(8'd248, 8'd0, 5'd16, 5'd16);
      do_draw(8'd10, 8'd10, 5'd0, 5'd16);
      do_draw(8'd10, 8'd10, 5'd16, 5'd0);
      do_draw(8'd100, 8'd20, 5'd31, 5'd31);
      do_draw(8'd7, 8'd7, 5'd1, 5'd1);
      do_write(13'd4095, 8'hA5);
      do_read(13'd4095);
      do_read(13'd100);

      // Random phases, each under its own window size; one runs without stalls.
      for (int p = 0; p < 9; p++) begin
         phase_plan(p, w, h, n);
         wait_idle();
         set_window(w, h);
         steady <= (p == 2);
         for (int k = 0; k < n; k++) send_random_request();
      end

      req_valid <= 1'b0;
      steady <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/gbt4_pkg.sv
sv/glyph_blit_tiled_4bpp_top.sv
dv/glyph_blit_checker.sv
dv/tb.sv
